// ===== design/range_set_filter_table_core_macros.svh =====
// Assertion macros for the range set filter table core.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef RANGE_SET_FILTER_TABLE_CORE_MACROS_SVH
`define RANGE_SET_FILTER_TABLE_CORE_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define RSFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define RSFT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rsft_pkg.sv =====
// Package for the range set filter table core: request/status codes,
// payload structs, sequencer states and sizing constants. No dependencies.
package rsft_pkg;

  localparam int unsigned MaxRangesDefault = 16;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ACCEPT = 2'd1,
    REQ_REJECT = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] range_low;
    logic [63:0] range_high;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] status;
    logic [4:0] ranges_used;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UNR,
    S_READ,
    S_EVAL,
    S_EXTRA,
    S_TAIL,
    S_COMMIT,
    S_DONE
  } state_t;

endpackage

// ===== design/range_set_filter_table_core.sv =====
// Top level of the range set filter table core: sequencer over a ping-pong
// range table. Depends on rsft_pkg, rsft_ram and the macros header.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------
//  in      | input     | in_valid / in_ready  | in_word  (in_t)
//  out     | output    | out_valid / out_ready| out_word (out_t)
//
// A request reads each held range in turn through the table RAM's single read
// port, then evaluates and writes it; a split or inserted range adds an extra
// write, and setup, tail, commit and result steps are added around these.
// Clears, bad ranges and lookups with no held ranges or while unrestricted
// go straight to the result.
// Reset is synchronous; it empties the table and sets the unrestricted state.
// A new word is taken while a finished result still waits on out_ready.
`include "range_set_filter_table_core_macros.svh"

module range_set_filter_table_core #(
  parameter int unsigned MAX_RANGES = rsft_pkg::MaxRangesDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsft_pkg::in_t in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output rsft_pkg::out_t out_word
);
  import rsft_pkg::*;

  localparam int unsigned IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned AW = IW + 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned NW = $clog2(MAX_RANGES + 2);
  localparam logic [63:0] ALL_ONES = '1;

  state_t        state, state_next;
  logic          bank, bank_next;
  logic          unr, unr_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [NW-1:0] n, n_next;
  logic          placed, placed_next;
  logic [63:0]   nl, nl_next, nh, nh_next;
  logic [1:0]    req, req_next;
  logic [63:0]   lo, lo_next, hi, hi_next;
  logic          hit, hit_next;
  logic          acc, acc_next;
  logic [1:0]    status, status_next;
  logic [63:0]   pend_lo, pend_lo_next, pend_hi, pend_hi_next;
  out_t          out_word_next;
  logic          out_valid_next;

  logic          wr_valid;
  logic [63:0]   wr_lo, wr_hi;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [127:0]  rd_data;
  logic [63:0]   el, eh;
  logic          last;
  logic [31:0]   used32;

  assign el = rd_data[127:64];
  assign eh = rd_data[63:0];
  assign wr_en = wr_valid && (n < NW'(MAX_RANGES));
  assign wr_addr = {~bank, n[IW-1:0]};
  assign rd_addr = {bank, idx[IW-1:0]};
  assign last = (CW'(idx + CW'(1)) == count);
  assign in_ready = (state == S_IDLE);

  rsft_ram #(
    .Width(128),
    .Depth(2 ** AW)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data({wr_lo, wr_hi}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_next    = state;
    bank_next     = bank;
    unr_next      = unr;
    count_next    = count;
    idx_next      = idx;
    n_next        = n;
    placed_next   = placed;
    nl_next       = nl;
    nh_next       = nh;
    req_next      = req;
    lo_next       = lo;
    hi_next       = hi;
    hit_next      = hit;
    acc_next      = acc;
    status_next   = status;
    pend_lo_next  = pend_lo;
    pend_hi_next  = pend_hi;
    out_valid_next = out_valid && !out_ready;
    out_word_next = out_word;
    wr_valid      = 1'b0;
    wr_lo         = el;
    wr_hi         = eh;
    used32        = 32'(count);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next    = in_word.req_type;
          lo_next     = in_word.range_low;
          hi_next     = in_word.range_high;
          nl_next     = in_word.range_low;
          nh_next     = in_word.range_high;
          idx_next    = '0;
          n_next      = '0;
          placed_next = 1'b0;
          hit_next    = 1'b0;
          acc_next    = 1'b0;
          status_next = ST_OK;
          unique case (in_word.req_type)
            REQ_LOOKUP: begin
              if (unr) begin
                acc_next   = 1'b1;
                state_next = S_DONE;
              end else if (count == '0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            REQ_CLEAR: begin
              unr_next   = 1'b1;
              count_next = '0;
              state_next = S_DONE;
            end
            default: begin
              if (in_word.range_low > in_word.range_high) begin
                status_next = ST_ORDER;
                state_next  = S_DONE;
              end else if (unr) begin
                state_next = S_UNR;
              end else if (count == '0) begin
                state_next = (in_word.req_type == REQ_ACCEPT) ? S_TAIL : S_COMMIT;
              end else begin
                state_next = S_READ;
              end
            end
          endcase
        end
      end

      S_UNR: begin
        state_next = S_COMMIT;
        if (req == REQ_ACCEPT) begin
          wr_valid = 1'b1;
          wr_lo    = lo;
          wr_hi    = hi;
        end else if (lo != '0) begin
          wr_valid = 1'b1;
          wr_lo    = '0;
          wr_hi    = lo - 64'd1;
          if (hi != ALL_ONES) begin
            pend_lo_next = hi + 64'd1;
            pend_hi_next = ALL_ONES;
            state_next   = S_EXTRA;
          end
        end else if (hi != ALL_ONES) begin
          wr_valid = 1'b1;
          wr_lo    = hi + 64'd1;
          wr_hi    = ALL_ONES;
        end
      end

      S_READ: begin
        state_next = S_EVAL;
      end

      S_EVAL: begin
        logic extra;
        extra = 1'b0;
        if (req == REQ_LOOKUP) begin
          hit_next = hit | ((lo >= el) && (lo <= eh));
        end else if (req == REQ_ACCEPT) begin
          if (({1'b0, eh} + 65'd1) < {1'b0, lo}) begin
            wr_valid = 1'b1;
          end else if ({1'b0, el} > ({1'b0, hi} + 65'd1)) begin
            wr_valid = 1'b1;
            if (!placed) begin
              // insert the merged range ahead of this entry
              wr_lo        = nl;
              wr_hi        = nh;
              placed_next  = 1'b1;
              pend_lo_next = el;
              pend_hi_next = eh;
              extra        = 1'b1;
            end
          end else begin
            if (el < nl) nl_next = el;
            if (eh > nh) nh_next = eh;
          end
        end else begin
          if ((eh < lo) || (el > hi)) begin
            wr_valid = 1'b1;
          end else if (el < lo) begin
            wr_valid = 1'b1;
            wr_hi    = lo - 64'd1;
            if (eh > hi) begin
              pend_lo_next = hi + 64'd1;
              pend_hi_next = eh;
              extra        = 1'b1;
            end
          end else if (eh > hi) begin
            wr_valid = 1'b1;
            wr_lo    = hi + 64'd1;
          end
        end
        if (extra) begin
          state_next = S_EXTRA;
        end else if (!last) begin
          idx_next   = CW'(idx + CW'(1));
          state_next = S_READ;
        end else if (req == REQ_LOOKUP) begin
          acc_next   = hit | ((lo >= el) && (lo <= eh));
          state_next = S_DONE;
        end else begin
          state_next = (req == REQ_ACCEPT) ? S_TAIL : S_COMMIT;
        end
      end

      S_EXTRA: begin
        wr_valid = 1'b1;
        wr_lo    = pend_lo;
        wr_hi    = pend_hi;
        if (unr) begin
          state_next = S_COMMIT;
        end else if (!last) begin
          idx_next   = CW'(idx + CW'(1));
          state_next = S_READ;
        end else begin
          state_next = (req == REQ_ACCEPT) ? S_TAIL : S_COMMIT;
        end
      end

      S_TAIL: begin
        if (!placed) begin
          wr_valid = 1'b1;
          wr_lo    = nl;
          wr_hi    = nh;
        end
        state_next = S_COMMIT;
      end

      S_COMMIT: begin
        if (n > NW'(MAX_RANGES)) begin
          status_next = ST_FULL;
        end else begin
          // new list becomes live
          bank_next   = ~bank;
          count_next  = CW'(n);
          unr_next    = 1'b0;
          status_next = ST_OK;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next            = 1'b1;
          out_word_next.accepted    = acc;
          out_word_next.status      = status;
          out_word_next.ranges_used = unr ? 5'd0 : used32[4:0];
          state_next                = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (wr_valid) begin
      n_next = NW'(n + NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bank      <= 1'b0;
      unr       <= 1'b1;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bank      <= bank_next;
      unr       <= unr_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    n        <= n_next;
    placed   <= placed_next;
    nl       <= nl_next;
    nh       <= nh_next;
    req      <= req_next;
    lo       <= lo_next;
    hi       <= hi_next;
    hit      <= hit_next;
    acc      <= acc_next;
    status   <= status_next;
    pend_lo  <= pend_lo_next;
    pend_hi  <= pend_hi_next;
    out_word <= out_word_next;
  end

  `RSFT_ASSERT(a_write_idle_bank, wr_en |-> (wr_addr[AW-1] != bank), "write hit live bank")
  `RSFT_ASSERT(a_count_bound, count <= CW'(MAX_RANGES), "range count above table size")
  `RSFT_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `RSFT_ASSERT(a_unr_empty, unr |-> (count == '0), "unrestricted with ranges held")

endmodule

// ===== design/rsft_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rsft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== test/tb_range_set_filter_table_core.sv =====
// Testbench for range_set_filter_table_core: drives requests over valid/ready
// and checks each result word against an interval-set predictor.
// Depends on rsft_pkg and the core RTL.
module tb_range_set_filter_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rsft_pkg::*;

  localparam int unsigned TableDepth = MaxRangesDefault;
  localparam logic [63:0] TopValue = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned CycleLimit = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_word;
  logic out_valid;
  logic out_ready;
  out_t out_word;

  // Predicted table state.
  logic [63:0] set_lo[TableDepth];
  logic [63:0] set_hi[TableDepth];
  int unsigned set_count;
  bit set_open;

  // Candidate list built by a request before it is committed.
  logic [63:0] cand_lo[TableDepth + 2];
  logic [63:0] cand_hi[TableDepth + 2];
  int unsigned cand_n;

  out_t pending_results[$];
  int unsigned mismatches;
  longint unsigned cycle_count;
  bit sender_idle_on;
  bit receiver_idle_on;
  int unsigned hold_off_cycles;

  range_set_filter_table_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit set_holds(logic [63:0] v);
    if (set_open) return 1'b1;
    for (int i = 0; i < set_count; i++) begin
      if (v >= set_lo[i] && v <= set_hi[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void cand_add(logic [63:0] lo, logic [63:0] hi);
    if (cand_n < TableDepth + 2) begin
      cand_lo[cand_n] = lo;
      cand_hi[cand_n] = hi;
    end
    cand_n++;
  endfunction

  // Commit the candidate list, or report full and keep the old table.
  function automatic status_t store_ranges();
    if (cand_n > TableDepth) return ST_FULL;
    for (int i = 0; i < cand_n; i++) begin
      set_lo[i] = cand_lo[i];
      set_hi[i] = cand_hi[i];
    end
    set_count = cand_n;
    set_open = 1'b0;
    return ST_OK;
  endfunction

  function automatic status_t merge_range(logic [63:0] low, logic [63:0] high);
    logic [63:0] nl;
    logic [63:0] nh;
    bit placed;
    nl = low;
    nh = high;
    placed = 1'b0;
    cand_n = 0;
    if (!set_open) begin
      for (int i = 0; i < set_count; i++) begin
        if (set_hi[i] < low && low - set_hi[i] > 64'd1) begin
          cand_add(set_lo[i], set_hi[i]);
        end else if (set_lo[i] > high && set_lo[i] - high > 64'd1) begin
          if (!placed) begin
            cand_add(nl, nh);
            placed = 1'b1;
          end
          cand_add(set_lo[i], set_hi[i]);
        end else begin
          if (set_lo[i] < nl) nl = set_lo[i];
          if (set_hi[i] > nh) nh = set_hi[i];
        end
      end
    end
    if (!placed) cand_add(nl, nh);
    return store_ranges();
  endfunction

  function automatic status_t cut_range(logic [63:0] low, logic [63:0] high);
    cand_n = 0;
    if (set_open) begin
      if (low > 64'd0) cand_add(64'd0, low - 64'd1);
      if (high < TopValue) cand_add(high + 64'd1, TopValue);
      return store_ranges();
    end
    for (int i = 0; i < set_count; i++) begin
      if (set_hi[i] < low || set_lo[i] > high) begin
        cand_add(set_lo[i], set_hi[i]);
      end else begin
        if (set_lo[i] < low) cand_add(set_lo[i], low - 64'd1);
        if (set_hi[i] > high) cand_add(high + 64'd1, set_hi[i]);
      end
    end
    return store_ranges();
  endfunction

  function automatic out_t predict_result(in_t w);
    out_t r;
    r = '0;
    r.status = ST_OK;
    case (req_t'(w.req_type))
      REQ_LOOKUP: r.accepted = set_holds(w.range_low);
      REQ_CLEAR: begin
        set_open = 1'b1;
        set_count = 0;
      end
      default: begin
        if (w.range_low > w.range_high) r.status = ST_ORDER;
        else if (req_t'(w.req_type) == REQ_ACCEPT)
          r.status = merge_range(w.range_low, w.range_high);
        else r.status = cut_range(w.range_low, w.range_high);
      end
    endcase
    r.ranges_used = set_open ? 5'd0 : set_count[4:0];
    return r;
  endfunction

  // Called at a falling edge; valid stays up between words unless idling.
  task automatic send_word(req_t op, logic [63:0] low, logic [63:0] high);
    in_t w;
    w.req_type = op;
    w.range_low = low;
    w.range_high = high;
    while (sender_idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results = {pending_results, predict_result(w)};
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_word);
      end else begin
        out_t exp_r;
        exp_r = pending_results.pop_front();
        if (out_word.accepted !== exp_r.accepted || out_word.status !== exp_r.status ||
            out_word.ranges_used !== exp_r.ranges_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_r, out_word);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else out_ready <= !(receiver_idle_on && $urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("range_set_filter_table_core regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand_wide();
    return {$urandom(), $urandom()};
  endfunction

  // Values drawn near a small window so that ranges meet, touch and split.
  function automatic logic [63:0] rand_near();
    case ($urandom_range(9))
      0: return rand_wide();
      1: return TopValue - $urandom_range(40);
      default: return 64'($urandom_range(200));
    endcase
  endfunction

  task automatic test_directed();
    send_word(REQ_LOOKUP, TopValue, 0);
    send_word(REQ_ACCEPT, 10, 5);
    send_word(REQ_REJECT, TopValue, 0);
    send_word(REQ_ACCEPT, 10, 20);
    send_word(REQ_LOOKUP, 9, 0);
    send_word(REQ_LOOKUP, 10, 0);
    send_word(REQ_LOOKUP, 20, TopValue);
    send_word(REQ_ACCEPT, 21, 30);
    send_word(REQ_ACCEPT, 0, 0);
    send_word(REQ_ACCEPT, TopValue, TopValue);
    send_word(REQ_REJECT, 15, 15);
    send_word(REQ_LOOKUP, 15, 0);
    send_word(REQ_ACCEPT, 0, TopValue);
    send_word(REQ_CLEAR, 0, 0);
    send_word(REQ_REJECT, 0, 5);
    send_word(REQ_CLEAR, TopValue, TopValue);
    send_word(REQ_REJECT, 5, TopValue);
    send_word(REQ_CLEAR, 0, 0);
    send_word(REQ_REJECT, 0, TopValue);
    send_word(REQ_LOOKUP, 0, 0);
    send_word(REQ_CLEAR, 0, 0);
    send_word(REQ_REJECT, 100, 200);
    send_word(REQ_LOOKUP, 150, 0);
    send_word(REQ_LOOKUP, TopValue, 0);
    wait_drained();
  endtask

  // Fill the table to full, then one more, then trim the edges of entries when full.
  task automatic test_table_full();
    send_word(REQ_CLEAR, 0, 0);
    for (int i = 0; i < TableDepth + 1; i++) send_word(REQ_ACCEPT, 64'(i * 4), 64'(i * 4 + 1));
    send_word(REQ_REJECT, 4, 4);
    send_word(REQ_REJECT, 1, 1);
    send_word(REQ_LOOKUP, 1, 0);
    wait_drained();
  endtask

  // Hold the receiver off while requests keep coming so the core backs up.
  task automatic test_back_pressure();
    @(negedge clk);
    hold_off_cycles <= 400;
    for (int i = 0; i < 12; i++) send_word(req_t'($urandom_range(3)), rand_near(), rand_near());
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_items);
    logic [63:0] a;
    logic [63:0] b;
    req_t op;
    for (int i = 0; i < n_items; i++) begin
      sender_idle_on = !(i >= 300 && i < 500);
      receiver_idle_on = sender_idle_on;
      a = rand_near();
      b = rand_near();
      case ($urandom_range(19))
        0: op = REQ_CLEAR;
        1, 2, 3, 4, 5, 6: op = REQ_LOOKUP;
        7, 8, 9, 10, 11, 12: op = REQ_ACCEPT;
        default: op = REQ_REJECT;
      endcase
      // Mostly ordered bounds; the rest exercise low above high.
      if (op != REQ_LOOKUP && a > b && $urandom_range(9) != 0) send_word(op, b, a);
      else send_word(op, a, b);
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
    set_lo = '{default: '0};
    set_hi = '{default: '0};
    set_count = 0;
    set_open = 1'b1;
    cand_n = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    test_back_pressure();
    test_random(1480);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("range_set_filter_table_core regression: pass");
    else
      $display("range_set_filter_table_core regression: fail");
    $finish;
  end
endmodule
